[rtl/nms_pkg.sv]
// Shared constants, command and status types for the box suppression block.
// Used by nms_ctrl, nms_datapath and box_non_max_suppression.
`default_nettype none

package nms_pkg;

    localparam int MAX_BOXES  = 64;
    localparam int COORD_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam int SCORE_W    = 32;
    localparam int THR_W      = 17;
    localparam int IDX_W      = $clog2(MAX_BOXES);
    localparam int CNT_W      = $clog2(MAX_BOXES + 1);
    localparam int SPAN_W     = COORD_BITS + 1;
    localparam int AREA_W     = 2 * SPAN_W;
    localparam int UNI_W      = AREA_W + 1;
    localparam int LHS_W      = AREA_W + 16;
    localparam int PROD_W     = UNI_W + THR_W;
    localparam int CMP_W      = (LHS_W > PROD_W) ? LHS_W : PROD_W;
    localparam int PADDR_W    = 3;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(19661);
    localparam logic             REG_THR   = 1'b0;

    typedef enum logic [1:0] {
        MODE_SCAN  = 2'd0,
        MODE_FETCH = 2'd1,
        MODE_SUPP  = 2'd2
    } mode_t;

    typedef struct packed {
        logic  start;
        mode_t mode;
        logic  emit;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic out_valid;
        logic alive_empty;
    } sts_t;

endpackage

`default_nettype wire

[rtl/nms_ctrl.sv]
// Sequencer for loading, best-box scan, pick fetch, suppression and emit.
// Depends on nms_pkg.
`default_nettype none

module nms_ctrl
    import nms_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_accept,
    input  wire logic in_final,
    input  wire sts_t sts,
    output logic      s_ready,
    output cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_LOAD, S_SCAN, S_FETCH, S_SUPP, S_EMIT, S_OUT
    } state_t;

    state_t state_reg;
    cmd_t   cmd_reg;
    logic   done_ok;

    assign s_ready = (state_reg == S_LOAD);
    assign cmd     = cmd_reg;
    // status updates in the cycle after a start pulse, so done is ignored while start is high
    assign done_ok = !cmd_reg.start && sts.done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            cmd_reg.start <= 1'b0;
            cmd_reg.mode  <= MODE_SCAN;
            cmd_reg.emit  <= 1'b0;
        end else begin
            cmd_reg.start <= 1'b0;
            cmd_reg.emit  <= 1'b0;
            case (state_reg)
                S_LOAD: begin
                    if (in_accept && in_final) begin
                        state_reg     <= S_SCAN;
                        cmd_reg.start <= 1'b1;
                        cmd_reg.mode  <= MODE_SCAN;
                    end
                end
                S_SCAN: begin
                    if (done_ok) begin
                        state_reg     <= S_FETCH;
                        cmd_reg.start <= 1'b1;
                        cmd_reg.mode  <= MODE_FETCH;
                    end
                end
                S_FETCH: begin
                    if (done_ok) begin
                        state_reg     <= S_SUPP;
                        cmd_reg.start <= 1'b1;
                        cmd_reg.mode  <= MODE_SUPP;
                    end
                end
                S_SUPP: begin
                    if (done_ok) begin
                        state_reg    <= S_EMIT;
                        cmd_reg.emit <= 1'b1;
                    end
                end
                S_EMIT: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!sts.out_valid) begin
                        if (sts.alive_empty) begin
                            state_reg <= S_LOAD;
                        end else begin
                            state_reg     <= S_SCAN;
                            cmd_reg.start <= 1'b1;
                            cmd_reg.mode  <= MODE_SCAN;
                        end
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/nms_datapath.sv]
// Box stores, alive mask, read sweep, overlap pipeline and output register.
// Depends on nms_pkg.
`default_nettype none

module nms_datapath
    import nms_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire cmd_t                      cmd,
    output sts_t                           sts,
    input  wire logic                      in_accept,
    input  wire logic [FIELD_W-1:0]        in_left_x,
    input  wire logic [FIELD_W-1:0]        in_top_y,
    input  wire logic [FIELD_W-1:0]        in_right_x,
    input  wire logic [FIELD_W-1:0]        in_bottom_y,
    input  wire logic signed [SCORE_W-1:0] in_score,
    input  wire logic [THR_W-1:0]          thr,
    input  wire logic                      m_ready,
    output logic                           m_valid,
    output logic [FIELD_W-1:0]             m_left_x,
    output logic [FIELD_W-1:0]             m_top_y,
    output logic [FIELD_W-1:0]             m_right_x,
    output logic [FIELD_W-1:0]             m_bottom_y,
    output logic signed [SCORE_W-1:0]      m_score,
    output logic                           m_final,
    output logic                           m_overflow
);

    localparam int C = COORD_BITS;

    logic [4*C-1:0]     corner_mem [MAX_BOXES];
    logic [SCORE_W-1:0] score_mem  [MAX_BOXES];

    logic [MAX_BOXES-1:0] alive_reg, alive_next;
    logic [CNT_W-1:0]     count_reg;
    logic                 overflow_reg;

    mode_t            mode_reg;
    logic             busy_reg;
    logic [IDX_W-1:0] rd_idx_reg, rd_addr, last_idx;

    logic                      v1_reg;
    logic [IDX_W-1:0]          idx1_reg;
    logic [4*C-1:0]            corner1_reg;
    logic signed [SCORE_W-1:0] score1_reg;

    logic                      found_reg;
    logic [IDX_W-1:0]          best_reg;
    logic signed [SCORE_W-1:0] best_score_reg;
    logic [4*C-1:0]            pick_reg;
    logic [SPAN_W-1:0]         pw_reg, ph_reg;
    logic [AREA_W-1:0]         parea_reg;

    logic              v2_reg, v3_reg, v4_reg, v5_reg;
    logic [IDX_W-1:0]  idx2_reg, idx3_reg, idx4_reg, idx5_reg;
    logic [SPAN_W-1:0] iw2_reg, ih2_reg, bw2_reg, bh2_reg;
    logic [AREA_W-1:0] inter3_reg, areab3_reg, inter4_reg;
    logic [UNI_W-1:0]  uni4_reg;
    logic [CMP_W-1:0]  lhs5_reg, prod5_reg;

    logic [C-1:0] l1, t1, r1, d1, al, at, ar, ad, bl, bt, br, bd;
    logic         supp_hit, out_take, store_ok;

    function automatic logic [SPAN_W-1:0] span(input logic [C-1:0] lo, input logic [C-1:0] hi);
        span = (hi >= lo) ? SPAN_W'({1'b0, hi} - {1'b0, lo} + 1'b1) : '0;
    endfunction

    assign store_ok = (count_reg < CNT_W'(MAX_BOXES));
    assign last_idx = IDX_W'(count_reg - 1'b1);
    assign rd_addr  = (mode_reg == MODE_FETCH) ? best_reg : rd_idx_reg;
    assign out_take = m_valid && m_ready;

    assign sts.done        = !busy_reg && !v1_reg && !v2_reg && !v3_reg && !v4_reg && !v5_reg;
    assign sts.out_valid   = m_valid;
    assign sts.alive_empty = (alive_reg == '0);

    // memories: write on load, registered read on sweep
    always_ff @(posedge aclk) begin
        if (in_accept && store_ok) begin
            corner_mem[count_reg[IDX_W-1:0]] <= {in_bottom_y[C-1:0], in_right_x[C-1:0],
                                                 in_top_y[C-1:0], in_left_x[C-1:0]};
            score_mem[count_reg[IDX_W-1:0]]  <= in_score;
        end
        corner1_reg <= corner_mem[rd_addr];
        score1_reg  <= score_mem[rd_addr];
        idx1_reg    <= rd_addr;
    end

    // sweep sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            v1_reg     <= 1'b0;
            mode_reg   <= MODE_SCAN;
            rd_idx_reg <= '0;
        end else begin
            v1_reg <= busy_reg;
            if (cmd.start) begin
                busy_reg   <= 1'b1;
                mode_reg   <= cmd.mode;
                rd_idx_reg <= '0;
            end else if (busy_reg) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                if (mode_reg == MODE_FETCH || rd_idx_reg == last_idx) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // best-score search: strict greater keeps the earlier arrival
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.start && cmd.mode == MODE_SCAN) begin
            found_reg <= 1'b0;
        end else if (v1_reg && mode_reg == MODE_SCAN && alive_reg[idx1_reg]
                     && (!found_reg || score1_reg > best_score_reg)) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg && mode_reg == MODE_SCAN && alive_reg[idx1_reg]
            && (!found_reg || score1_reg > best_score_reg)) begin
            best_reg       <= idx1_reg;
            best_score_reg <= score1_reg;
        end
        if (v1_reg && mode_reg == MODE_FETCH) begin
            pick_reg <= corner1_reg;
        end
        pw_reg    <= span(pick_reg[C-1:0], pick_reg[3*C-1:2*C]);
        ph_reg    <= span(pick_reg[2*C-1:C], pick_reg[4*C-1:3*C]);
        parea_reg <= AREA_W'(pw_reg * ph_reg);
    end

    // overlap pipeline
    always_comb begin
        al = pick_reg[C-1:0];     at = pick_reg[2*C-1:C];
        ar = pick_reg[3*C-1:2*C]; ad = pick_reg[4*C-1:3*C];
        bl = corner1_reg[C-1:0];     bt = corner1_reg[2*C-1:C];
        br = corner1_reg[3*C-1:2*C]; bd = corner1_reg[4*C-1:3*C];
        l1 = (al > bl) ? al : bl;
        t1 = (at > bt) ? at : bt;
        r1 = (ar < br) ? ar : br;
        d1 = (ad < bd) ? ad : bd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v2_reg <= v1_reg && mode_reg == MODE_SUPP;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        idx2_reg   <= idx1_reg;
        iw2_reg    <= span(l1, r1);
        ih2_reg    <= span(t1, d1);
        bw2_reg    <= span(bl, br);
        bh2_reg    <= span(bt, bd);
        idx3_reg   <= idx2_reg;
        inter3_reg <= AREA_W'(iw2_reg * ih2_reg);
        areab3_reg <= AREA_W'(bw2_reg * bh2_reg);
        idx4_reg   <= idx3_reg;
        inter4_reg <= inter3_reg;
        uni4_reg   <= UNI_W'({1'b0, parea_reg} + {1'b0, areab3_reg} - {1'b0, inter3_reg});
        idx5_reg   <= idx4_reg;
        lhs5_reg   <= CMP_W'({inter4_reg, 16'h0000});
        prod5_reg  <= CMP_W'(thr * uni4_reg);
    end

    assign supp_hit = v5_reg && (lhs5_reg > prod5_reg);

    always_comb begin
        alive_next = alive_reg;
        if (in_accept && store_ok) begin
            alive_next[count_reg[IDX_W-1:0]] = 1'b1;
        end
        if (v1_reg && mode_reg == MODE_FETCH) begin
            alive_next[best_reg] = 1'b0;
        end
        if (supp_hit) begin
            alive_next[idx5_reg] = 1'b0;
        end
    end

    // set bookkeeping; drop the set once its last word is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg    <= '0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            alive_reg <= alive_next;
            if (out_take && m_final) begin
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end else if (in_accept) begin
                if (store_ok) begin
                    count_reg <= count_reg + 1'b1;
                end else begin
                    overflow_reg <= 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.emit) begin
            m_valid <= 1'b1;
        end else if (out_take) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_left_x   <= FIELD_W'(pick_reg[C-1:0]);
            m_top_y    <= FIELD_W'(pick_reg[2*C-1:C]);
            m_right_x  <= FIELD_W'(pick_reg[3*C-1:2*C]);
            m_bottom_y <= FIELD_W'(pick_reg[4*C-1:3*C]);
            m_score    <= best_score_reg;
            m_final    <= (alive_reg == '0);
            m_overflow <= overflow_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/box_non_max_suppression.sv]
// Greedy box suppression: loads one box word per cycle while s_ready is high, then
// emits kept boxes. Per pick: scan of N entries, fetch, suppression sweep of N
// entries plus the overlap pipeline (span, area, union and compare registers), all
// through one memory read port. Each kept box waits on m_ready before the next pick;
// s_ready stays low until the last kept box of a set has been taken.
// Reset (aresetn low, synchronous) empties the set; threshold returns to 19661.
// Depends on nms_pkg, nms_ctrl, nms_datapath.
`default_nettype none

module box_non_max_suppression
    import nms_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [PADDR_W-1:0]        paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [FIELD_W-1:0]        s_left_x,
    input  wire logic [FIELD_W-1:0]        s_top_y,
    input  wire logic [FIELD_W-1:0]        s_right_x,
    input  wire logic [FIELD_W-1:0]        s_bottom_y,
    input  wire logic signed [SCORE_W-1:0] s_box_score,
    input  wire logic                      s_final_box,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [FIELD_W-1:0]             m_kept_left_x,
    output logic [FIELD_W-1:0]             m_kept_top_y,
    output logic [FIELD_W-1:0]             m_kept_right_x,
    output logic [FIELD_W-1:0]             m_kept_bottom_y,
    output logic signed [SCORE_W-1:0]      m_kept_score,
    output logic                           m_final_pick,
    output logic                           m_overflowed
);

    logic [THR_W-1:0] thr_reg;
    logic             in_accept;
    cmd_t             cmd;
    sts_t             sts;

    assign pready    = 1'b1;
    assign in_accept = s_valid && s_ready;
    assign prdata    = (paddr[2] == REG_THR) ? 32'(thr_reg) : 32'h0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_THR) begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    nms_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_final  (s_final_box),
        .sts       (sts),
        .s_ready   (s_ready),
        .cmd       (cmd)
    );

    nms_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .in_accept   (in_accept),
        .in_left_x   (s_left_x),
        .in_top_y    (s_top_y),
        .in_right_x  (s_right_x),
        .in_bottom_y (s_bottom_y),
        .in_score    (s_box_score),
        .thr         (thr_reg),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_left_x    (m_kept_left_x),
        .m_top_y     (m_kept_top_y),
        .m_right_x   (m_kept_right_x),
        .m_bottom_y  (m_kept_bottom_y),
        .m_score     (m_kept_score),
        .m_final     (m_final_pick),
        .m_overflow  (m_overflowed)
    );

endmodule

`default_nettype wire
